/* hw/rtl/tts_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and cell helpers for the scrollback terminal.
// Used by the line store, the history ring and the top level.
package tts_pkg;

    localparam int ROW_WIDTH_DEF     = 80;
    localparam int SCREEN_ROWS_DEF   = 25;
    localparam int HISTORY_DEPTH_DEF = 1024;

    localparam int CELL_W    = 13;
    localparam int PAGE_STEP = 20;

    typedef enum logic [1:0] {
        ACT_PUT    = 2'd0,
        ACT_BS     = 2'd1,
        ACT_SCROLL = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] SC_UP    = 8'h48;
    localparam logic [7:0] SC_DOWN  = 8'h50;
    localparam logic [7:0] SC_PGUP  = 8'h49;
    localparam logic [7:0] SC_PGDN  = 8'h51;
    localparam logic [7:0] SC_HOME  = 8'h47;
    localparam logic [7:0] SC_END   = 8'h4f;

    localparam logic [2:0] REG_TEXT    = 3'd0;
    localparam logic [2:0] REG_TITLE   = 3'd1;
    localparam logic [2:0] REG_ACCENT  = 3'd2;
    localparam logic [2:0] REG_STATUS  = 3'd3;
    localparam logic [2:0] REG_OK      = 3'd4;
    localparam logic [2:0] REG_ERROR   = 3'd5;
    localparam logic [2:0] REG_DEFAULT = 3'd6;

    localparam logic [4:0] STY_TEXT   = 5'd0;
    localparam logic [4:0] STY_TITLE  = 5'd1;
    localparam logic [4:0] STY_ACCENT = 5'd2;
    localparam logic [4:0] STY_STATUS = 5'd3;
    localparam logic [4:0] STY_OK     = 5'd4;
    localparam logic [4:0] STY_ERROR  = 5'd5;

    // A space in the text style, as the theme stands after reset.
    localparam logic [CELL_W-1:0] CELL_RESET = {STY_TEXT, CH_SPACE};

    typedef struct packed {
        logic [7:0] text;
        logic [7:0] title;
        logic [7:0] accent;
        logic [7:0] status;
        logic [7:0] ok;
        logic [7:0] error;
        logic [7:0] dflt;
    } t_theme;

    localparam t_theme THEME_RESET = '{text: 8'd7, title: 8'd15, accent: 8'd11,
                                       status: 8'd14, ok: 8'd10, error: 8'd12,
                                       dflt: 8'd7};

    typedef struct packed {
        logic re;
        logic we;
        logic clr;
    } t_line_ctl;

    typedef enum logic [3:0] {
        S_IDLE, S_PUT, S_ADV, S_BS, S_BCOPY, S_SCR,
        S_RD_A, S_RD_B, S_RD_C, S_RD_D, S_RD_E, S_FIN
    } t_state;

    function automatic logic [4:0] style_of(input t_theme th, input logic [7:0] a);
        logic [4:0] s;
        if (a == th.title) s = STY_TITLE;
        else if (a == th.accent) s = STY_ACCENT;
        else if (a == th.status) s = STY_STATUS;
        else if (a == th.ok) s = STY_OK;
        else if (a == th.error) s = STY_ERROR;
        else if (a == th.text) s = STY_TEXT;
        else s = {1'b1, a[3:0]};
        return s;
    endfunction

    function automatic logic [7:0] attr_of(input t_theme th, input logic [4:0] s);
        logic [7:0] a;
        case (s)
            STY_TITLE:  a = th.title;
            STY_ACCENT: a = th.accent;
            STY_STATUS: a = th.status;
            STY_OK:     a = th.ok;
            STY_ERROR:  a = th.error;
            STY_TEXT:   a = th.text;
            default:    a = {th.text[7:4], s[3:0]};
        endcase
        return a;
    endfunction

    function automatic logic [CELL_W-1:0] make_cell(input t_theme th, input logic [7:0] ch,
                                                   input logic [7:0] a);
        return {style_of(th, a), ch};
    endfunction

endpackage

/* hw/rtl/tts_line.sv */
`timescale 1ns / 1ps
// Current row store: one synchronous memory plus a valid bit per cell.
// Depends on tts_pkg; a cell that is not valid reads as the last blank cell.
module tts_line #(
    parameter int ROW_WIDTH = tts_pkg::ROW_WIDTH_DEF,
    localparam int CW = $clog2(ROW_WIDTH)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tts_pkg::t_line_ctl        i_ctl,
    input  logic [CW-1:0]             i_raddr,
    input  logic [CW-1:0]             i_waddr,
    input  logic [tts_pkg::CELL_W-1:0] i_wdata,
    input  logic [tts_pkg::CELL_W-1:0] i_blank,
    output logic [tts_pkg::CELL_W-1:0] o_rdata
);

    logic [tts_pkg::CELL_W-1:0] r_mem [ROW_WIDTH];
    logic [ROW_WIDTH-1:0]       r_valid;
    logic [tts_pkg::CELL_W-1:0] r_q;
    logic                       r_q_valid;
    logic [tts_pkg::CELL_W-1:0] r_blank;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
            r_blank   <= tts_pkg::CELL_RESET;
        end else begin
            if (i_ctl.re) begin
                r_q_valid <= r_valid[i_raddr];
            end
            // Clearing the row drops every valid bit and records the new blank.
            if (i_ctl.clr) begin
                r_valid <= '0;
                r_blank <= i_blank;
            end else if (i_ctl.we) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_q_valid ? r_q : r_blank;

endmodule

/* hw/rtl/tts_ring.sv */
`timescale 1ns / 1ps
// History ring: one write port, one registered read port.
// Depends on tts_pkg for the cell width and the default depth.
module tts_ring #(
    parameter int CELLS = tts_pkg::HISTORY_DEPTH_DEF * tts_pkg::ROW_WIDTH_DEF,
    localparam int AW = $clog2(CELLS)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [tts_pkg::CELL_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [tts_pkg::CELL_W-1:0] o_rdata
);

    logic [tts_pkg::CELL_W-1:0] r_mem [CELLS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hw/rtl/text_terminal_scrollback.sv */
`timescale 1ns / 1ps
// Scrollback terminal top level: sequencer around the row store and history ring.
// Depends on tts_pkg, tts_line and tts_ring.
//
//  channel | handshake                  | payload
//  in      | i_in_valid / o_in_ready    | action, char, attribute, scan, row, column
//  out     | o_out_valid / i_out_ready  | cell, cursor, view top, oldest row, line start
//  cfg     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A scroll runs S_SCR then S_FIN, a read S_RD_A to S_RD_E then S_FIN, and a carriage
// return or printable character S_PUT then S_FIN. A line advance copies the row into
// the ring in S_ADV; a backspace across rows copies it back in S_BCOPY. A tab repeats per space.
// Reset is synchronous and needs no clearing pass; the ring is never read unwritten.
// A waiting result holds in the output register while the next word is accepted.
module text_terminal_scrollback #(
    parameter int ROW_WIDTH     = tts_pkg::ROW_WIDTH_DEF,
    parameter int SCREEN_ROWS   = tts_pkg::SCREEN_ROWS_DEF,
    parameter int HISTORY_DEPTH = tts_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_color_attribute,
    input  logic [7:0]  i_scan_code,
    input  logic [4:0]  i_screen_row,
    input  logic [6:0]  i_screen_column,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attribute,
    output logic [4:0]  o_cursor_screen_row,
    output logic [6:0]  o_cursor_screen_column,
    output logic [31:0] o_view_top_row,
    output logic [31:0] o_oldest_kept_row,
    output logic        o_at_line_start,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int CW    = $clog2(ROW_WIDTH);
    localparam int CNTW  = $clog2(ROW_WIDTH + 1);
    localparam int HW    = $clog2(HISTORY_DEPTH);
    localparam int CELLS = HISTORY_DEPTH * ROW_WIDTH;
    localparam int RAW   = $clog2(CELLS);
    localparam int CLW   = tts_pkg::CELL_W;
    localparam logic [31:0]   LAT_OFS  = 32'(SCREEN_ROWS - 1);
    localparam logic [31:0]   OLD_OFS  = 32'(HISTORY_DEPTH - 1);
    localparam logic [31:0]   SR32     = 32'(SCREEN_ROWS);
    localparam logic [31:0]   HD32     = 32'(HISTORY_DEPTH);
    localparam logic [7:0]    W8       = 8'(ROW_WIDTH);
    localparam logic [CNTW-1:0] WCNT   = CNTW'(ROW_WIDTH);
    localparam logic [HW-1:0] RR_LAST  = HW'(HISTORY_DEPTH - 1);
    localparam logic [RAW-1:0] W_RA    = RAW'(ROW_WIDTH);
    localparam logic [32:0]   STEP33   = 33'(tts_pkg::PAGE_STEP);

    tts_pkg::t_state r_state, n_state;
    tts_pkg::t_theme r_theme;

    logic [1:0]        r_act, n_act;
    logic [7:0]        r_char, n_char, r_attr, n_attr, r_scan, n_scan;
    logic [4:0]        r_srow, n_srow;
    logic [6:0]        r_scol, n_scol;
    logic [31:0]       r_cursor, n_cursor, r_view, n_view;
    logic [7:0]        r_col, n_col;
    logic              r_lwn, n_lwn, r_follow, n_follow;
    logic [HW-1:0]     r_ring_row, n_ring_row, r_d, n_d, r_idx, n_idx;
    logic [3:0]        r_n, n_n;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic              r_pv, n_pv;
    logic [RAW-1:0]    r_wa, n_wa, r_ra, n_ra;
    logic [CW-1:0]     r_wcol, n_wcol;
    logic              r_oor, n_oor, r_cur, n_cur;
    logic [CLW-1:0]    r_cell, n_cell;
    logic              r_ov, n_ov;
    logic [7:0]        r_o_char, n_o_char, r_o_attr, n_o_attr;
    logic [4:0]        r_o_crow, n_o_crow;
    logic [6:0]        r_o_ccol, n_o_ccol;
    logic [31:0]       r_o_view, n_o_view, r_o_old, n_o_old;
    logic              r_o_lws, n_o_lws;

    logic [31:0]       latest, oldest, fin_view, put_view;
    logic [7:0]        colp, colp1;
    logic [7:0]        put_ch;
    logic [CLW-1:0]    blank_now;
    logic              in_acc, out_load, adv_done;
    logic [32:0]       rd_row, v33, o33, l33;
    logic [HW:0]       idx_wrap;

    tts_pkg::t_line_ctl line_ctl;
    logic [CW-1:0]     line_raddr, line_waddr;
    logic [CLW-1:0]    line_wdata, line_q;
    logic              ring_we, ring_re;
    logic [RAW-1:0]    ring_waddr, ring_raddr;
    logic [CLW-1:0]    ring_wdata, ring_q;

    tts_line #(.ROW_WIDTH(ROW_WIDTH)) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (line_ctl),
        .i_raddr (line_raddr),
        .i_waddr (line_waddr),
        .i_wdata (line_wdata),
        .i_blank (blank_now),
        .o_rdata (line_q)
    );

    tts_ring #(.CELLS(CELLS)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_q)
    );

    assign o_in_ready = (r_state == tts_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = !r_ov || i_out_ready;
    assign adv_done   = (r_cnt == WCNT) && !r_pv;

    assign latest = (r_cursor >= SR32) ? r_cursor - LAT_OFS : '0;
    assign oldest = (r_cursor >= HD32) ? r_cursor - OLD_OFS : '0;

    assign colp   = (r_col >= W8) ? 8'd0 : r_col;
    assign colp1  = colp + 8'd1;
    assign put_ch = (r_char == tts_pkg::CH_TAB) ? tts_pkg::CH_SPACE : r_char;
    assign blank_now = tts_pkg::make_cell(r_theme, tts_pkg::CH_SPACE, r_theme.dflt);

    assign rd_row   = {1'b0, r_view} + 33'(r_srow);
    assign v33      = {1'b0, r_view};
    assign o33      = {1'b0, oldest};
    assign l33      = {1'b0, latest};
    assign idx_wrap = {1'b0, r_ring_row} + (HW+1)'(HISTORY_DEPTH) - {1'b0, r_d};

    assign put_view = r_follow ? latest : r_view;

    always_comb begin
        case (tts_pkg::t_action'(r_act))
            tts_pkg::ACT_PUT: fin_view = (put_view < oldest) ? oldest : put_view;
            tts_pkg::ACT_BS:  fin_view = r_follow ? latest : r_view;
            default:          fin_view = r_view;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            tts_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (tts_pkg::t_action'(i_action))
                        tts_pkg::ACT_PUT:    n_state = tts_pkg::S_PUT;
                        tts_pkg::ACT_BS:     n_state = tts_pkg::S_BS;
                        tts_pkg::ACT_SCROLL: n_state = tts_pkg::S_SCR;
                        default:             n_state = tts_pkg::S_RD_A;
                    endcase
                end
            end
            tts_pkg::S_PUT: begin
                if (r_char == tts_pkg::CH_CR) n_state = tts_pkg::S_FIN;
                else if (r_char == tts_pkg::CH_LF) n_state = tts_pkg::S_ADV;
                else if (colp1 == W8) n_state = tts_pkg::S_ADV;
                else if (r_n == 4'd1) n_state = tts_pkg::S_FIN;
                else n_state = tts_pkg::S_PUT;
            end
            tts_pkg::S_ADV: begin
                if (adv_done) n_state = (r_n != 4'd0) ? tts_pkg::S_PUT : tts_pkg::S_FIN;
            end
            tts_pkg::S_BS: begin
                if (r_col != 8'd0) n_state = tts_pkg::S_FIN;
                else if (r_cursor != 32'd0) n_state = tts_pkg::S_BCOPY;
                else n_state = tts_pkg::S_FIN;
            end
            tts_pkg::S_BCOPY: begin
                if (adv_done) n_state = tts_pkg::S_FIN;
            end
            tts_pkg::S_SCR:  n_state = tts_pkg::S_FIN;
            tts_pkg::S_RD_A: n_state = tts_pkg::S_RD_B;
            tts_pkg::S_RD_B: n_state = tts_pkg::S_RD_C;
            tts_pkg::S_RD_C: n_state = tts_pkg::S_RD_D;
            tts_pkg::S_RD_D: n_state = tts_pkg::S_RD_E;
            tts_pkg::S_RD_E: n_state = tts_pkg::S_FIN;
            tts_pkg::S_FIN: begin
                if (out_load) n_state = tts_pkg::S_IDLE;
            end
            default: n_state = tts_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_act = r_act; n_char = r_char; n_attr = r_attr; n_scan = r_scan;
        n_srow = r_srow; n_scol = r_scol;
        n_cursor = r_cursor; n_view = r_view; n_col = r_col; n_lwn = r_lwn;
        n_follow = r_follow; n_ring_row = r_ring_row; n_d = r_d; n_idx = r_idx;
        n_n = r_n; n_cnt = r_cnt; n_pv = r_pv; n_wa = r_wa; n_ra = r_ra;
        n_wcol = r_wcol; n_oor = r_oor; n_cur = r_cur; n_cell = r_cell;
        n_ov = r_ov && !i_out_ready;
        n_o_char = r_o_char; n_o_attr = r_o_attr; n_o_crow = r_o_crow;
        n_o_ccol = r_o_ccol; n_o_view = r_o_view; n_o_old = r_o_old; n_o_lws = r_o_lws;

        line_ctl   = '0;
        line_raddr = r_cnt[CW-1:0];
        line_waddr = colp[CW-1:0];
        line_wdata = tts_pkg::make_cell(r_theme, put_ch, r_attr);
        ring_we    = 1'b0;
        ring_re    = 1'b0;
        ring_waddr = r_wa;
        ring_wdata = line_q;
        ring_raddr = r_ra;

        case (r_state)
            tts_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_act  = i_action;
                    n_char = i_char_code;
                    n_attr = i_color_attribute;
                    n_scan = i_scan_code;
                    n_srow = i_screen_row;
                    n_scol = i_screen_column;
                    n_follow = (r_view == latest);
                    n_n = (i_char_code == tts_pkg::CH_TAB) ?
                          4'd8 - {1'b0, r_col[2:0]} : 4'd1;
                end
            end
            tts_pkg::S_PUT: begin
                if (r_char == tts_pkg::CH_CR) begin
                    n_col = 8'd0;
                    n_lwn = 1'b0;
                end else if (r_char == tts_pkg::CH_LF) begin
                    n_lwn = 1'b1;
                    n_n   = 4'd0;
                    n_wa  = RAW'(r_ring_row) * W_RA;
                    n_cnt = '0;
                    n_pv  = 1'b0;
                end else begin
                    n_lwn = 1'b0;
                    line_ctl.we = 1'b1;
                    n_col = colp1;
                    n_n   = r_n - 4'd1;
                    n_wa  = RAW'(r_ring_row) * W_RA;
                    n_cnt = '0;
                    n_pv  = 1'b0;
                end
            end
            tts_pkg::S_ADV: begin
                // Row copy into the ring; each ring write follows its line read in the next cycle.
                if (r_cnt != WCNT) begin
                    line_ctl.re = 1'b1;
                    n_cnt = r_cnt + CNTW'(1);
                end
                n_pv = (r_cnt != WCNT);
                if (r_pv) begin
                    ring_we = 1'b1;
                    n_wa = r_wa + RAW'(1);
                end
                if (adv_done) begin
                    if (r_cursor != 32'hffff_ffff) begin
                        n_cursor   = r_cursor + 32'd1;
                        n_ring_row = (r_ring_row == RR_LAST) ? '0 : r_ring_row + HW'(1);
                    end
                    n_col = 8'd0;
                    line_ctl.clr = 1'b1;
                end
            end
            tts_pkg::S_BS: begin
                line_wdata = blank_now;
                if (r_col != 8'd0) begin
                    n_col = r_col - 8'd1;
                    line_waddr = CW'(r_col - 8'd1);
                    line_ctl.we = 1'b1;
                end else if (r_cursor != 32'd0) begin
                    n_cursor   = r_cursor - 32'd1;
                    n_ring_row = (r_ring_row == '0) ? RR_LAST : r_ring_row - HW'(1);
                    n_ra  = RAW'(n_ring_row) * W_RA;
                    n_cnt = '0;
                    n_pv  = 1'b0;
                end
            end
            tts_pkg::S_BCOPY: begin
                if (r_cnt != WCNT) begin
                    ring_re = 1'b1;
                    n_ra    = r_ra + RAW'(1);
                    n_cnt   = r_cnt + CNTW'(1);
                    n_wcol  = r_cnt[CW-1:0];
                end
                n_pv = (r_cnt != WCNT);
                if (r_pv) begin
                    line_ctl.we = 1'b1;
                    line_waddr  = r_wcol;
                    line_wdata  = ring_q;
                end
                if (adv_done) begin
                    n_col = W8 - 8'd1;
                    line_ctl.we = 1'b1;
                    line_waddr  = CW'(ROW_WIDTH - 1);
                    line_wdata  = blank_now;
                end
            end
            tts_pkg::S_SCR: begin
                case (r_scan)
                    tts_pkg::SC_UP:   if (v33 > o33) n_view = r_view - 32'd1;
                    tts_pkg::SC_DOWN: if (v33 < l33) n_view = r_view + 32'd1;
                    tts_pkg::SC_PGUP:
                        n_view = (v33 > o33 + STEP33) ? r_view - 32'(tts_pkg::PAGE_STEP) : oldest;
                    tts_pkg::SC_PGDN:
                        n_view = (v33 + STEP33 < l33) ? r_view + 32'(tts_pkg::PAGE_STEP) : latest;
                    tts_pkg::SC_HOME: n_view = oldest;
                    tts_pkg::SC_END:  n_view = latest;
                    default:          n_view = r_view;
                endcase
            end
            tts_pkg::S_RD_A: begin
                n_oor = ({27'd0, r_srow} >= SR32) || ({1'b0, r_scol} >= W8) ||
                        (rd_row < o33) || (rd_row > {1'b0, r_cursor});
                n_cur = (rd_row == {1'b0, r_cursor});
                n_d   = HW'(r_cursor - rd_row[31:0]);
            end
            tts_pkg::S_RD_B: begin
                // Ring slot of the row, counted back from the cursor's slot.
                n_idx = (r_ring_row >= r_d) ? r_ring_row - r_d : idx_wrap[HW-1:0];
            end
            tts_pkg::S_RD_C: begin
                n_ra = RAW'(r_idx) * W_RA + RAW'(r_scol);
            end
            tts_pkg::S_RD_D: begin
                ring_re = !r_oor && !r_cur;
                line_ctl.re = !r_oor && r_cur;
                line_raddr  = r_scol[CW-1:0];
            end
            tts_pkg::S_RD_E: begin
                n_cell = r_oor ? blank_now : (r_cur ? line_q : ring_q);
            end
            tts_pkg::S_FIN: begin
                if (out_load) begin
                    n_view = fin_view;
                    n_ov   = 1'b1;
                    if (r_act == tts_pkg::ACT_READ) begin
                        n_o_char = r_cell[7:0];
                        n_o_attr = tts_pkg::attr_of(r_theme, r_cell[12:8]);
                    end else begin
                        n_o_char = 8'd0;
                        n_o_attr = 8'd0;
                    end
                    if (fin_view == latest) begin
                        n_o_crow = 5'(r_cursor - fin_view);
                        n_o_ccol = r_col[6:0];
                    end else begin
                        n_o_crow = 5'(SCREEN_ROWS - 1);
                        n_o_ccol = 7'd0;
                    end
                    n_o_view = fin_view;
                    n_o_old  = oldest;
                    n_o_lws  = r_lwn;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tts_pkg::S_IDLE;
            r_theme    <= tts_pkg::THEME_RESET;
            r_cursor   <= '0;
            r_view     <= '0;
            r_col      <= '0;
            r_lwn      <= 1'b1;
            r_ring_row <= '0;
            r_n        <= '0;
            r_cnt      <= '0;
            r_pv       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cursor   <= n_cursor;
            r_view     <= n_view;
            r_col      <= n_col;
            r_lwn      <= n_lwn;
            r_ring_row <= n_ring_row;
            r_n        <= n_n;
            r_cnt      <= n_cnt;
            r_pv       <= n_pv;
            r_ov       <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tts_pkg::REG_TEXT:    r_theme.text   <= i_cfg_data;
                    tts_pkg::REG_TITLE:   r_theme.title  <= i_cfg_data;
                    tts_pkg::REG_ACCENT:  r_theme.accent <= i_cfg_data;
                    tts_pkg::REG_STATUS:  r_theme.status <= i_cfg_data;
                    tts_pkg::REG_OK:      r_theme.ok     <= i_cfg_data;
                    tts_pkg::REG_ERROR:   r_theme.error  <= i_cfg_data;
                    tts_pkg::REG_DEFAULT: r_theme.dflt   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act; r_char <= n_char; r_attr <= n_attr; r_scan <= n_scan;
        r_srow <= n_srow; r_scol <= n_scol; r_follow <= n_follow;
        r_d <= n_d; r_idx <= n_idx; r_wa <= n_wa; r_ra <= n_ra; r_wcol <= n_wcol;
        r_oor <= n_oor; r_cur <= n_cur; r_cell <= n_cell;
        r_o_char <= n_o_char; r_o_attr <= n_o_attr; r_o_crow <= n_o_crow;
        r_o_ccol <= n_o_ccol; r_o_view <= n_o_view; r_o_old <= n_o_old;
        r_o_lws <= n_o_lws;
    end

    assign o_out_valid            = r_ov;
    assign o_cell_char            = r_o_char;
    assign o_cell_attribute       = r_o_attr;
    assign o_cursor_screen_row    = r_o_crow;
    assign o_cursor_screen_column = r_o_ccol;
    assign o_view_top_row         = r_o_view;
    assign o_oldest_kept_row      = r_o_old;
    assign o_at_line_start        = r_o_lws;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= W8)
        else $error("cursor column beyond row width");

    a_ring_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring_row <= RR_LAST)
        else $error("ring slot out of range");

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tts_pkg::S_FIN && !r_ov) |=> r_ov)
        else $error("finished word not loaded into output register");

    a_no_ring_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ring_we && ring_re))
        else $error("ring read and write in the same cycle");

endmodule
